>>> hdl/gmlp_pkg.sv
package gmlp_pkg;

  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_LEAD     = 3'd1;
  localparam logic [2:0] PH_SIGNED   = 3'd2;
  localparam logic [2:0] PH_INT      = 3'd3;
  localparam logic [2:0] PH_DOTNODIG = 3'd4;
  localparam logic [2:0] PH_FRAC     = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;
  localparam logic [2:0] PH_SKIP     = 3'd7;

  localparam logic [2:0] LET_NONE = 3'd0;
  localparam logic [2:0] LET_G    = 3'd1;
  localparam logic [2:0] LET_X    = 3'd2;
  localparam logic [2:0] LET_F    = 3'd3;
  localparam logic [2:0] LET_P    = 3'd4;

  localparam logic [2:0] MATCH_FAIL = 3'd7;
  localparam logic [2:0] MATCH_DONE = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [7:0] END_TEXT [4] = '{8'h47, 8'h31, 8'h34, 8'h34};

  localparam logic [35:0] MAG_CAP = 36'd4000000000;

  typedef struct packed {
    logic [2:0]  letter;
    logic [2:0]  phase;
    logic        neg;
    logic [31:0] acc;
    logic [1:0]  frac_cnt;
  } word_t;

  typedef struct packed {
    logic [7:0]  g;
    logic [31:0] x;
    logic [31:0] f;
    logic [31:0] p;
  } held_t;

  typedef struct packed {
    logic [7:0]         g_code;
    logic signed [31:0] x_um;
    logic signed [31:0] feed_um_s;
    logic [31:0]        p_value;
    logic               is_end_test;
  } res_t;

endpackage

>>> hdl/gcode_move_line_parser_top.sv
// Parses one G-code move line streamed one character per word and returns the
// G, X, F and P values together with a flag for a line that reads exactly G144.
// The block takes one character every cycle while not stalled; a character
// passes an input register and then the parser, and the result register loads a
// line's result as its line-end character leaves the input register. The only
// stall is at the result register: a line-end character waits in the input
// register while the previous result is untaken; ordinary characters flow on.
module gcode_move_line_parser_top
  import gmlp_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_in_i,
  input  logic               line_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         g_code_o,
  output logic signed [31:0] x_um_o,
  output logic signed [31:0] feed_um_s_o,
  output logic [31:0]        p_value_o,
  output logic               is_end_test_o
);

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       adv;
  logic       out_vld_q;
  res_t       res;
  res_t       out_q;

  assign adv = in_vld_q && (!in_last_q || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_char_q <= char_in_i;
      in_last_q <= line_end_i;
    end
  end

  gmlp_word #(
    .MAX_LINE(MAX_LINE)
  ) u_word (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign g_code_o      = out_q.g_code;
  assign x_um_o        = out_q.x_um;
  assign feed_um_s_o   = out_q.feed_um_s;
  assign p_value_o     = out_q.p_value;
  assign is_end_test_o = out_q.is_end_test;

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && in_last_q && out_vld_q && out_stall_i |-> in_stall_o)
    else $error("line end advanced over an untaken result");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> out_vld_q)
    else $error("line end gave no result");

  a_end_test_g: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && is_end_test_o |-> g_code_o == 8'd144)
    else $error("end test flagged without G144");

endmodule

>>> hdl/gmlp_word.sv
module gmlp_word
  import gmlp_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output res_t       result_o
);

  localparam int CntW = $clog2(MAX_LINE);
  localparam logic [CntW-1:0] CntLim = CntW'(MAX_LINE - 1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  word_t            word_q, word_d;
  held_t            held_q, held_d, fin_held;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [2:0]       match_q, match_d;
  logic [2:0]       fin_match;

  function automatic logic [31:0] scaled(logic neg, logic [31:0] m);
    logic [31:0] v;
    v = m;
    if (neg) begin
      if (v > 32'h8000_0000) begin
        v = 32'h8000_0000;
      end
      return 32'(-v);
    end
    if (v > 32'h7FFF_FFFF) begin
      v = 32'h7FFF_FFFF;
    end
    return v;
  endfunction

  function automatic held_t close_held(word_t w, held_t h);
    held_t       n;
    logic [31:0] u;
    n = h;
    u = w.neg ? 32'(-w.acc) : w.acc;
    if (w.phase == PH_INT || w.phase == PH_FRAC || w.phase == PH_DONE) begin
      unique case (w.letter)
        LET_G:   n.g = u[7:0];
        LET_P:   n.p = u;
        LET_X:   n.x = scaled(w.neg, w.acc);
        LET_F:   n.f = scaled(w.neg, w.acc);
        default: n = h;
      endcase
    end
    return n;
  endfunction

  function automatic logic [35:0] frac_weight(logic [1:0] idx, logic [3:0] d);
    logic [35:0] r;
    r = 36'd0;
    unique case (idx)
      2'd0:    r = 36'(d) * 36'd100;
      2'd1:    r = 36'(d) * 36'd10;
      default: r = 36'(d);
    endcase
    return r;
  endfunction

  function automatic word_t add_digit(word_t w, logic [3:0] d, logic is_real, logic frac);
    word_t       n;
    logic [35:0] wide;
    n = w;
    wide = {4'd0, w.acc};
    if (!is_real) begin
      n.acc = 32'(w.acc * 32'd10 + 32'(d));
    end else begin
      if (frac) begin
        if (w.frac_cnt != 2'd3) begin
          wide = wide + frac_weight(w.frac_cnt, d);
          n.frac_cnt = w.frac_cnt + 2'd1;
        end
      end else begin
        wide = (wide << 3) + (wide << 1) + 36'(d) * 36'd1000;
      end
      if (wide > MAG_CAP) begin
        wide = MAG_CAP;
      end
      n.acc = wide[31:0];
    end
    return n;
  endfunction

  function automatic word_t take_char(word_t w, logic [7:0] c);
    word_t n;
    logic  is_real;
    logic  digit;
    logic  blank;
    logic  add;
    logic  frac;
    n = w;
    is_real = (w.letter == LET_X) || (w.letter == LET_F);
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    blank = (c >= CH_TAB) && (c <= CH_CR);
    add = 1'b0;
    frac = 1'b0;
    unique case (w.phase) inside
      PH_START: begin
        unique case (c)
          CH_G:    n.letter = LET_G;
          CH_X:    n.letter = LET_X;
          CH_F:    n.letter = LET_F;
          CH_P:    n.letter = LET_P;
          default: n.letter = w.letter;
        endcase
        n.phase = (n.letter == LET_NONE) ? PH_SKIP : PH_LEAD;
      end
      PH_LEAD, PH_SIGNED: begin
        if (digit) begin
          n.phase = PH_INT;
          add = 1'b1;
        end else if (w.phase == PH_LEAD && blank) begin
          n.phase = w.phase;
        end else if (w.phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
          n.neg = (c == CH_MINUS);
          n.phase = PH_SIGNED;
        end else if (is_real && c == CH_DOT) begin
          n.phase = PH_DOTNODIG;
        end else begin
          n.phase = PH_SKIP;
        end
      end
      PH_INT: begin
        if (digit) begin
          add = 1'b1;
        end else if (is_real && c == CH_DOT) begin
          n.phase = PH_FRAC;
        end else begin
          n.phase = PH_DONE;
        end
      end
      PH_DOTNODIG: begin
        if (digit) begin
          n.phase = PH_FRAC;
          add = 1'b1;
          frac = 1'b1;
        end else begin
          n.phase = PH_SKIP;
        end
      end
      PH_FRAC: begin
        if (digit) begin
          add = 1'b1;
          frac = 1'b1;
        end else begin
          n.phase = PH_DONE;
        end
      end
      default: n = w;
    endcase
    if (add) begin
      n = add_digit(n, c[3:0], is_real, frac);
    end
    return n;
  endfunction

  always_comb begin
    word_d = word_q;
    held_d = held_q;
    cnt_d = cnt_q;
    match_d = match_q;
    if (cnt_q < CntLim) begin
      if (char_i == CH_NUL) begin
        held_d = close_held(word_q, held_q);
        word_d = '0;
        cnt_d = CntLim;
      end else begin
        cnt_d = cnt_q + CntOne;
        if (match_q < MATCH_DONE && char_i == END_TEXT[match_q[1:0]]) begin
          match_d = match_q + 3'd1;
        end else begin
          match_d = MATCH_FAIL;
        end
        if (char_i == CH_SPACE) begin
          held_d = close_held(word_q, held_q);
          word_d = '0;
        end else begin
          word_d = take_char(word_q, char_i);
        end
      end
    end
    fin_held = close_held(word_d, held_d);
    fin_match = match_d;
    if (last_i) begin
      word_d = '0;
      held_d = '0;
      cnt_d = '0;
      match_d = 3'd0;
    end
  end

  assign result_o.g_code      = fin_held.g;
  assign result_o.x_um        = fin_held.x;
  assign result_o.feed_um_s   = fin_held.f;
  assign result_o.p_value     = fin_held.p;
  assign result_o.is_end_test = (fin_match == MATCH_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      held_q <= '0;
      cnt_q <= '0;
      match_q <= 3'd0;
    end else if (step_i) begin
      word_q <= word_d;
      held_q <= held_d;
      cnt_q <= cnt_d;
      match_q <= match_d;
    end
  end

endmodule
